### sv/bpfa_pkg.sv
// Shared types and codes for the bitmap page-frame allocator.
// Used by bpfa_ctrl, bpfa_dpath and the top level; depends on nothing.
package bpfa_pkg;

   // Request operation codes (req_tuser)
   typedef enum logic [1:0] {
      OPC_ALLOC   = 2'd0,
      OPC_RELEASE = 2'd1,
      OPC_MARK    = 2'd2,
      OPC_INIT    = 2'd3
   } opcode_type;

   // Result status codes (rsp_tuser)
   typedef enum logic [1:0] {
      RSP_DONE         = 2'd0,
      RSP_NO_FREE      = 2'd1,
      RSP_OUT_OF_RANGE = 2'd2,
      RSP_NO_CHANGE    = 2'd3
   } rsp_status_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_ALLOC_WR,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_NOFREE_RESP,
      ST_RANGE_RESP,
      ST_SWEEP,
      ST_INIT_RESP
   } state_type;

   // Datapath operations, one per cycle
   typedef enum logic [2:0] {
      DP_NONE,
      DP_ACCEPT,
      DP_SCAN_RD,
      DP_WORD_RD,
      DP_ALLOC_COMMIT,
      DP_RMW_COMMIT,
      DP_RESP,
      DP_SWEEP_WR
   } dp_op_type;

   // Controller to datapath
   typedef struct packed {
      dp_op_type      op;
      rsp_status_type status;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic hit;        // scanned word has a free bit
      logic bit_used;   // addressed page bit in the word just read
      logic out_free;   // result register can take a new result
      logic oor;        // requested page beyond the map
      logic free_zero;  // no free page left
      logic sweep_last; // sweep at the last map word
      logic is_release; // current transaction is a release
   } dp_stat_type;

endpackage

### sv/bpfa_ctrl.sv
// Sequencer for the page-frame allocator: one transaction at a time.
// Depends on bpfa_pkg; drives bpfa_dpath through dp_cmd_type.
module bpfa_ctrl
   import bpfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic [1:0]  req_opcode,
   output logic        req_tready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type      state_ff, state_in;
   opcode_type     opc;
   rsp_status_type rmw_status;

   assign opc = opcode_type'(req_opcode);

   // Release frees a used page, mark uses a free page; otherwise no change
   always_comb begin
      if (stat.is_release) begin
         rmw_status = stat.bit_used ? RSP_DONE : RSP_NO_CHANGE;
      end else begin
         rmw_status = stat.bit_used ? RSP_NO_CHANGE : RSP_DONE;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (opc)
                  OPC_ALLOC:   state_in = stat.free_zero ? ST_NOFREE_RESP : ST_SCAN;
                  OPC_RELEASE,
                  OPC_MARK:    state_in = stat.oor ? ST_RANGE_RESP : ST_RMW_RD;
                  OPC_INIT:    state_in = ST_SWEEP;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (stat.hit) state_in = ST_ALLOC_WR;
         end
         ST_ALLOC_WR,
         ST_RMW_WR,
         ST_NOFREE_RESP,
         ST_RANGE_RESP,
         ST_INIT_RESP: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         ST_RMW_RD: state_in = ST_RMW_WR;
         ST_SWEEP: begin
            if (stat.sweep_last) state_in = ST_INIT_RESP;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd.op     = DP_NONE;
      cmd.status = RSP_DONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.op = DP_SWEEP_WR;
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = DP_ACCEPT;
         end
         ST_SCAN: begin
            if (!stat.hit) cmd.op = DP_SCAN_RD;
         end
         ST_ALLOC_WR: begin
            if (stat.out_free) cmd.op = DP_ALLOC_COMMIT;
         end
         ST_RMW_RD: cmd.op = DP_WORD_RD;
         ST_RMW_WR: begin
            cmd.status = rmw_status;
            if (stat.out_free) cmd.op = DP_RMW_COMMIT;
         end
         ST_NOFREE_RESP: begin
            cmd.status = RSP_NO_FREE;
            if (stat.out_free) cmd.op = DP_RESP;
         end
         ST_RANGE_RESP: begin
            cmd.status = RSP_OUT_OF_RANGE;
            if (stat.out_free) cmd.op = DP_RESP;
         end
         ST_SWEEP: cmd.op = DP_SWEEP_WR;
         ST_INIT_RESP: begin
            if (stat.out_free) cmd.op = DP_RESP;
         end
         default: cmd.op = DP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/bpfa_dpath.sv
// Datapath of the page-frame allocator: used-bit map memory, pointers,
// free counter, kernel-end register and result register. Depends on bpfa_pkg.
module bpfa_dpath
   import bpfa_pkg::*;
#(
   parameter int PAGE_COUNT      = 8192,
   parameter int PAGE_ADDR_SHIFT = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_addr,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [31:0] rsp_alloc_address,
   output logic [1:0]  rsp_status,
   output logic [13:0] rsp_free_count
);

   localparam int MAP_WORDS   = (PAGE_COUNT + 31) / 32;
   localparam int PW          = $clog2(PAGE_COUNT);      // page index bits
   localparam int WAW         = PW - 5;                  // map word index bits
   localparam int FW          = $clog2(PAGE_COUNT + 1);  // free count bits
   localparam int LOW_RESERVE = (1024 * 1024) >> PAGE_ADDR_SHIFT;
   localparam int ROUND_UP    = (1 << PAGE_ADDR_SHIFT) - 1;

   // Used-bit map
   logic [31:0]    map_mem [MAP_WORDS];
   logic [31:0]    rd_data_ff;
   logic           rd_en;
   logic           wr_en;
   logic [WAW-1:0] wr_addr;
   logic [31:0]    wr_data;

   logic [WAW-1:0] ptr_ff, ptr_in;
   logic [WAW-1:0] rd_word_ff, rd_word_in;
   logic [4:0]     bit_ff, bit_in;
   logic           data_vld_ff, data_vld_in;
   logic           release_ff, release_in;
   logic [FW-1:0]  reserve_ff, reserve_in;
   logic [FW-1:0]  free_ff, free_in;
   logic [31:0]    kend_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_addr_ff, rsp_addr_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [13:0]    rsp_free_ff, rsp_free_in;

   opcode_type     opc;
   logic [31:0]    req_page;
   logic [4:0]     zero_bit;
   logic [31:0]    zero_onehot;
   logic [PW-1:0]  alloc_page;
   logic [32:0]    kpages;
   logic [32:0]    rsv_max;
   logic [32:0]    rsv_clamp;
   logic [FW-1:0]  ptr_ext;
   logic [FW-1:0]  rsv_word;
   logic [31:0]    sweep_pattern;
   logic           out_free;
   logic           load_rsp;

   assign opc      = opcode_type'(req_opcode);
   assign req_page = req_addr >> PAGE_ADDR_SHIFT;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Lowest clear bit of the word read
   always_comb begin
      zero_bit = 5'd0;
      for (int i = 31; i >= 0; i--) begin
         if (!rd_data_ff[i]) zero_bit = 5'(i);
      end
   end
   assign zero_onehot = 32'd1 << zero_bit;
   assign alloc_page  = {rd_word_ff, zero_bit};

   // Init reservation: max(ceil(kernel end), 1 MB) in pages, clamped
   always_comb begin
      kpages    = ({1'b0, kend_ff} + 33'(ROUND_UP)) >> PAGE_ADDR_SHIFT;
      rsv_max   = (kpages > 33'(LOW_RESERVE)) ? kpages : 33'(LOW_RESERVE);
      rsv_clamp = (rsv_max > 33'(PAGE_COUNT)) ? 33'(PAGE_COUNT) : rsv_max;
   end

   // Sweep word: full below the reserve boundary, partial at it, clear above
   assign ptr_ext  = FW'(ptr_ff);
   assign rsv_word = reserve_ff >> 5;
   always_comb begin
      if (ptr_ext < rsv_word) begin
         sweep_pattern = '1;
      end else if (ptr_ext == rsv_word) begin
         sweep_pattern = (32'd1 << reserve_ff[4:0]) - 32'd1;
      end else begin
         sweep_pattern = '0;
      end
   end

   // Status to the controller
   assign stat.hit        = data_vld_ff && (rd_data_ff != '1);
   assign stat.bit_used   = rd_data_ff[bit_ff];
   assign stat.out_free   = out_free;
   assign stat.oor        = req_page >= 32'(PAGE_COUNT);
   assign stat.free_zero  = (free_ff == '0);
   assign stat.sweep_last = (ptr_ff == WAW'(MAP_WORDS - 1));
   assign stat.is_release = release_ff;

   // Memory port control
   always_comb begin
      rd_en   = (cmd.op == DP_SCAN_RD) || (cmd.op == DP_WORD_RD);
      wr_en   = 1'b0;
      wr_addr = rd_word_ff;
      wr_data = rd_data_ff;
      unique case (cmd.op)
         DP_ALLOC_COMMIT: begin
            wr_en   = 1'b1;
            wr_data = rd_data_ff | zero_onehot;
         end
         DP_RMW_COMMIT: begin
            wr_en   = (cmd.status == RSP_DONE);
            wr_data = rd_data_ff ^ (32'd1 << bit_ff);
         end
         DP_SWEEP_WR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = sweep_pattern;
         end
         default: wr_en = 1'b0;
      endcase
   end

   // Pointers, flags and free counter
   always_comb begin
      ptr_in      = ptr_ff;
      rd_word_in  = rd_word_ff;
      bit_in      = bit_ff;
      data_vld_in = data_vld_ff;
      release_in  = release_ff;
      reserve_in  = reserve_ff;
      free_in     = free_ff;
      unique case (cmd.op)
         DP_ACCEPT: begin
            ptr_in      = (opc == OPC_RELEASE || opc == OPC_MARK) ?
                          req_page[PW-1:5] : '0;
            bit_in      = req_page[4:0];
            data_vld_in = 1'b0;
            release_in  = (opc == OPC_RELEASE);
            reserve_in  = FW'(rsv_clamp);
         end
         DP_SCAN_RD: begin
            ptr_in      = ptr_ff + 1'b1;
            rd_word_in  = ptr_ff;
            data_vld_in = 1'b1;
         end
         DP_WORD_RD: begin
            rd_word_in  = ptr_ff;
            data_vld_in = 1'b1;
         end
         DP_ALLOC_COMMIT: free_in = free_ff - 1'b1;
         DP_RMW_COMMIT: begin
            if (cmd.status == RSP_DONE) begin
               free_in = release_ff ? free_ff + 1'b1 : free_ff - 1'b1;
            end
         end
         DP_SWEEP_WR: begin
            ptr_in = ptr_ff + 1'b1;
            if (stat.sweep_last) free_in = FW'(PAGE_COUNT) - reserve_ff;
         end
         default: ptr_in = ptr_ff;
      endcase
   end

   // Result register
   assign load_rsp = (cmd.op == DP_ALLOC_COMMIT) || (cmd.op == DP_RMW_COMMIT) ||
                     (cmd.op == DP_RESP);
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = (cmd.op == DP_ALLOC_COMMIT) ?
                         (32'(alloc_page) << PAGE_ADDR_SHIFT) : '0;
         rsp_status_in = cmd.status;
         rsp_free_in   = 14'(free_in);
      end
   end

   // Map memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) map_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= map_mem[ptr_ff];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         data_vld_ff  <= 1'b0;
         reserve_ff   <= '0;
         free_ff      <= FW'(PAGE_COUNT);
         kend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         data_vld_ff  <= data_vld_in;
         reserve_ff   <= reserve_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) kend_ff <= csr_wr_data;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_word_ff    <= rd_word_in;
      bit_ff        <= bit_in;
      release_ff    <= release_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_alloc_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_free_count    = rsp_free_ff;

endmodule

### sv/bitmap_page_frame_allocator_unit.sv
// Bitmap page-frame allocator, top level: controller plus datapath.
// Depends on bpfa_pkg, bpfa_ctrl and bpfa_dpath.
//
// Usage:
//   req_ channel: one operation per transaction; req_tuser carries the
//   opcode (allocate, release, mark used, init), req_tdata the page address.
//   rsp_ channel: exactly one result per request; rsp_tuser is the status,
//   rsp_tdata the allocated address and the free page count after the op.
//   csr_wr_en/csr_wr_data write the kernel end address used by init.
// Sequence (accept to result loaded, one request in flight at a time):
//   release / mark          : read word, then modify and write
//   out of range / no free  : status result loaded without a map access
//   allocate                : scan from map word 0 to the first map word
//                             with a clear bit; the map RAM read port scans
//                             one word per cycle; then that bit is set and written
//   init                    : sweep of all MAP_WORDS map words, one map word written a cycle
//   Each returns to idle before the next request is taken.
// Reset: a clearing pass writes all MAP_WORDS map words
//   with req_tready low; csr writes are taken throughout.
// Stall: a result sits in the output register until taken; the next request
//   may be accepted meanwhile, but its result waits for that register.
module bitmap_page_frame_allocator_unit
   import bpfa_pkg::*;
#(
   parameter int PAGE_COUNT      = 8192,
   parameter int PAGE_ADDR_SHIFT = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,  // kernel_end_addr
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] page_address
   input  logic [1:0]  req_tuser,    // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // [31:0] alloc_address, [45:32] free_count, zero pad
   output logic [1:0]  rsp_tuser     // [1:0] status
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic [31:0] rsp_alloc_address;
   logic [1:0]  rsp_status;
   logic [13:0] rsp_free_count;

   bpfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bpfa_dpath #(
      .PAGE_COUNT      (PAGE_COUNT),
      .PAGE_ADDR_SHIFT (PAGE_ADDR_SHIFT)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_opcode        (req_tuser),
      .req_addr          (req_tdata),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_alloc_address (rsp_alloc_address),
      .rsp_status        (rsp_status),
      .rsp_free_count    (rsp_free_count)
   );

   assign rsp_tdata = {2'b00, rsp_free_count, rsp_alloc_address};
   assign rsp_tuser = rsp_status;

   // No request is taken while the map is being swept
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_SWEEP_WR) |-> !req_tready)
      else $error("request accepted during map sweep");

   // A no-free-page result reports an empty free count
   a_nofree_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == RSP_NO_FREE) |-> (rsp_tdata[45:32] == '0))
      else $error("no-free status with non-zero free count");

   // Only a completed allocate carries a non-zero address
   a_addr_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != RSP_DONE) |-> (rsp_tdata[31:0] == '0))
      else $error("address returned with failure status");

   // A scan hit is only acted on with a free page counted
   a_hit_has_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_ALLOC_COMMIT) |-> !stat.free_zero)
      else $error("allocation committed with zero free pages");

endmodule
